// ===== sv/sbh_pkg.sv =====
package sbh_pkg;

    localparam int WORDS_PER_BLOCK = 16;
    localparam int ROUNDS          = 64;
    localparam int DIGEST_WORDS    = 8;

    typedef logic [31:0] word_t;
    typedef logic [$clog2(WORDS_PER_BLOCK)-1:0] pos_t;
    typedef logic [$clog2(ROUNDS)-1:0] round_t;
    typedef logic [$clog2(DIGEST_WORDS)-1:0] index_t;

    typedef word_t hash_t [DIGEST_WORDS];
    typedef word_t window_t [WORDS_PER_BLOCK];

    // Sequencer states, one-hot.
    typedef enum logic [3:0] {
        S_LOAD  = 4'b0001,
        S_ROUND = 4'b0010,
        S_ADD   = 4'b0100,
        S_OUT   = 4'b1000
    } state_t;

    localparam pos_t   LAST_POS   = pos_t'(WORDS_PER_BLOCK - 1);
    localparam round_t LAST_ROUND = round_t'(ROUNDS - 1);
    localparam index_t LAST_INDEX = index_t'(DIGEST_WORDS - 1);

    // Standard initial hash value.
    localparam hash_t INIT_HASH = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Round constants.
    localparam word_t ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Compression sigma on the first working word.
    function automatic word_t big_sigma0(input word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    // Compression sigma on the fifth working word.
    function automatic word_t big_sigma1(input word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    // Schedule sigma on the word fifteen back.
    function automatic word_t small_sigma0(input word_t x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    // Schedule sigma on the word two back.
    function automatic word_t small_sigma1(input word_t x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

// ===== sv/sbh_in_if.sv =====
interface sbh_in_if;
    import sbh_pkg::*;

    logic  valid;
    logic  ready;
    word_t msg_word;
    logic  first_block;
    logic  last_block;

    modport source (output valid, output msg_word, output first_block,
                    output last_block, input ready);
    modport sink (input valid, input msg_word, input first_block,
                  input last_block, output ready);
endinterface

// ===== sv/sbh_out_if.sv =====
interface sbh_out_if;
    import sbh_pkg::*;

    logic   valid;
    logic   ready;
    word_t  digest_word;
    index_t digest_index;
    logic   digest_end;

    modport source (output valid, output digest_word, output digest_index,
                    output digest_end, input ready);
    modport sink (input valid, input digest_word, input digest_index,
                  input digest_end, output ready);
endinterface

// ===== sv/sha256_block_hash.sv =====
// Takes one message word per cycle while loading; words 1 to 15 of a block are only shifted into the window.
// The sixteenth word starts the 64 rounds on the single round datapath, followed by the chaining
// add; no message word is taken during the rounds, the add or the digest output.
// A block marked last then presents its eight digest words, one per output request; the
// first is valid once the chaining add has completed.
// Reset (rst_n low, asynchronous) loads the initial hash value and clears the word position.
module sha256_block_hash (
    input  logic     clk,
    input  logic     rst_n,
    sbh_in_if.sink   msg_in,
    sbh_out_if.source digest_out
);
    import sbh_pkg::*;

    state_t  state_reg, state_next;
    pos_t    pos_reg, pos_next;
    round_t  round_reg, round_next;
    index_t  idx_reg, idx_next;
    logic    last_reg, last_next;
    hash_t   chain_reg, chain_next;
    hash_t   v_reg, v_next;
    window_t window_reg, window_next;

    logic    in_accept;
    logic    out_accept;
    word_t   sched_new;
    word_t   sum1;
    word_t   sum2;
    word_t   choose;
    word_t   major;

    // Handshakes.
    assign msg_in.ready = (state_reg == S_LOAD);
    assign in_accept    = msg_in.valid && msg_in.ready;
    assign out_accept   = digest_out.valid && digest_out.ready;

    // Digest words come straight from the chaining registers.
    assign digest_out.valid        = (state_reg == S_OUT);
    assign digest_out.digest_word  = chain_reg[idx_reg];
    assign digest_out.digest_index = idx_reg;
    assign digest_out.digest_end   = (idx_reg == LAST_INDEX);

    // Shared round unit: one schedule word and one compression round per cycle.
    always_comb
    begin
        sched_new = window_reg[0] + small_sigma0(window_reg[1]) + window_reg[9]
                  + small_sigma1(window_reg[14]);
        choose    = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        major     = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        sum1      = v_reg[7] + big_sigma1(v_reg[4]) + choose + ROUND_K[round_reg]
                  + window_reg[0];
        sum2      = big_sigma0(v_reg[0]) + major;
    end

    // Sequencer and datapath next state.
    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        round_next  = round_reg;
        idx_next    = idx_reg;
        last_next   = last_reg;
        chain_next  = chain_reg;
        v_next      = v_reg;
        window_next = window_reg;

        case (state_reg)
            S_LOAD:
            begin
                if (in_accept)
                begin
                    if (msg_in.first_block)
                    begin
                        chain_next = INIT_HASH;
                    end
                    for (int i = 0; i < WORDS_PER_BLOCK - 1; i++)
                    begin
                        window_next[i] = window_reg[i + 1];
                    end
                    window_next[WORDS_PER_BLOCK - 1] = msg_in.msg_word;
                    pos_next = pos_reg + pos_t'(1);
                    if (pos_reg == LAST_POS)
                    begin
                        if (msg_in.first_block)
                        begin
                            v_next = INIT_HASH;
                        end
                        else
                        begin
                            v_next = chain_reg;
                        end
                        last_next  = msg_in.last_block;
                        round_next = '0;
                        state_next = S_ROUND;
                    end
                end
            end
            S_ROUND:
            begin
                for (int i = 0; i < WORDS_PER_BLOCK - 1; i++)
                begin
                    window_next[i] = window_reg[i + 1];
                end
                window_next[WORDS_PER_BLOCK - 1] = sched_new;
                v_next[7]  = v_reg[6];
                v_next[6]  = v_reg[5];
                v_next[5]  = v_reg[4];
                v_next[4]  = v_reg[3] + sum1;
                v_next[3]  = v_reg[2];
                v_next[2]  = v_reg[1];
                v_next[1]  = v_reg[0];
                v_next[0]  = sum1 + sum2;
                round_next = round_reg + round_t'(1);
                if (round_reg == LAST_ROUND)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                for (int i = 0; i < DIGEST_WORDS; i++)
                begin
                    chain_next[i] = chain_reg[i] + v_reg[i];
                end
                idx_next   = '0;
                state_next = last_reg ? S_OUT : S_LOAD;
            end
            S_OUT:
            begin
                if (out_accept)
                begin
                    idx_next = idx_reg + index_t'(1);
                    if (idx_reg == LAST_INDEX)
                    begin
                        state_next = S_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Control and chaining registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            pos_reg   <= '0;
            round_reg <= '0;
            idx_reg   <= '0;
            last_reg  <= 1'b0;
            chain_reg <= INIT_HASH;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            round_reg <= round_next;
            idx_reg   <= idx_next;
            last_reg  <= last_next;
            chain_reg <= chain_next;
        end
    end

    // Working variables and schedule window.
    always_ff @(posedge clk)
    begin
        v_reg      <= v_next;
        window_reg <= window_next;
    end

endmodule
